FILE: hdl/encrypted_envelope_header_checker_macros.svh
// ----------------------------------------------------------------------------
// Envelope header checker assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ENCRYPTED_ENVELOPE_HEADER_CHECKER_MACROS_SVH
`define ENCRYPTED_ENVELOPE_HEADER_CHECKER_MACROS_SVH

// Same-cycle implication
`define EEHC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define EEHC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/eehc_pkg.sv
// ----------------------------------------------------------------------------
// Envelope header checker package
// Shared types, status codes, register map and the version table.
// ----------------------------------------------------------------------------
package eehc_pkg;

  // compare width wide enough for any byte count and any header length
  localparam int CMP_W = 25;
  localparam int MIN_ENVELOPE = 6;
  localparam int HDR_FIXED = 5;  // length byte + version + 3 iteration bytes

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_TINY          = 3'd1,
    ST_BAD_ID_LEN    = 3'd2,
    ST_SHORT_HEADER  = 3'd3,
    ST_UNKNOWN_VER   = 3'd4,
    ST_SHORT_PAYLOAD = 3'd5
  } status_t;

  localparam logic REG_MAX_ID_LEN   = 1'b0;
  localparam logic REG_ITER_SCALE   = 1'b1;

  localparam logic [1:0] CIPHER_ECB = 2'd0;
  localparam logic [1:0] CIPHER_CBC = 2'd1;
  localparam logic [1:0] CIPHER_CTR = 2'd2;
  localparam logic [1:0] CIPHER_GCM = 2'd3;

  localparam logic [1:0] PADDING_NUL   = 2'd0;
  localparam logic [1:0] PADDING_PKCS7 = 2'd1;
  localparam logic [1:0] PADDING_NONE  = 2'd2;

  localparam logic [1:0] TAG_HIDDEN  = 2'd0;
  localparam logic [1:0] TAG_EXPOSED = 2'd1;
  localparam logic [1:0] TAG_GCM     = 2'd2;

  typedef struct packed {
    logic [7:0]  max_id_length;
    logic [15:0] iteration_scale;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  id_len;
    logic [7:0]  version;
    logic [23:0] iters;
  } snap_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] mode;
    logic [4:0] iv;
    logic [1:0] pad;
    logic       comp;
    logic [1:0] auth;
    logic [4:0] abytes;
  } ver_info_t;

  // result item, last field in the lowest bits
  typedef struct packed {
    logic [2:0]  fill;
    logic [4:0]  tag_bytes;
    logic [1:0]  auth_kind;
    logic        compressed;
    logic [1:0]  pad_kind;
    logic [4:0]  iv_bytes;
    logic [1:0]  cipher_mode;
    logic [31:0] iteration_count;
    logic [7:0]  version_code;
    logic [7:0]  id_length;
    status_t     status;
    logic        envelope_ok;
  } result_t;

  function automatic ver_info_t ver_lookup(input logic [7:0] code);
    ver_info_t v;
    v = '0;
    v.hit = 1'b1;
    case (code)
      8'd0:  begin v.mode = CIPHER_ECB; v.iv = 5'd0;  v.pad = PADDING_NUL;
                   v.comp = 1'b0; v.auth = TAG_HIDDEN;  v.abytes = 5'd16; end
      8'd1:  begin v.mode = CIPHER_CBC; v.iv = 5'd16; v.pad = PADDING_NUL;
                   v.comp = 1'b0; v.auth = TAG_HIDDEN;  v.abytes = 5'd16; end
      8'd5:  begin v.mode = CIPHER_ECB; v.iv = 5'd0;  v.pad = PADDING_NUL;
                   v.comp = 1'b0; v.auth = TAG_EXPOSED; v.abytes = 5'd3; end
      8'd6:  begin v.mode = CIPHER_ECB; v.iv = 5'd0;  v.pad = PADDING_PKCS7;
                   v.comp = 1'b0; v.auth = TAG_HIDDEN;  v.abytes = 5'd4; end
      8'd7:  begin v.mode = CIPHER_ECB; v.iv = 5'd0;  v.pad = PADDING_PKCS7;
                   v.comp = 1'b1; v.auth = TAG_HIDDEN;  v.abytes = 5'd4; end
      8'd10: begin v.mode = CIPHER_CBC; v.iv = 5'd16; v.pad = PADDING_NUL;
                   v.comp = 1'b0; v.auth = TAG_EXPOSED; v.abytes = 5'd4; end
      8'd11: begin v.mode = CIPHER_CBC; v.iv = 5'd16; v.pad = PADDING_PKCS7;
                   v.comp = 1'b0; v.auth = TAG_HIDDEN;  v.abytes = 5'd4; end
      8'd12: begin v.mode = CIPHER_CBC; v.iv = 5'd16; v.pad = PADDING_PKCS7;
                   v.comp = 1'b1; v.auth = TAG_HIDDEN;  v.abytes = 5'd4; end
      8'd15: begin v.mode = CIPHER_CTR; v.iv = 5'd12; v.pad = PADDING_NONE;
                   v.comp = 1'b0; v.auth = TAG_HIDDEN;  v.abytes = 5'd4; end
      8'd16: begin v.mode = CIPHER_CTR; v.iv = 5'd12; v.pad = PADDING_NONE;
                   v.comp = 1'b1; v.auth = TAG_HIDDEN;  v.abytes = 5'd4; end
      8'd20: begin v.mode = CIPHER_GCM; v.iv = 5'd12; v.pad = PADDING_NONE;
                   v.comp = 1'b0; v.auth = TAG_GCM;     v.abytes = 5'd4; end
      8'd21: begin v.mode = CIPHER_GCM; v.iv = 5'd12; v.pad = PADDING_NONE;
                   v.comp = 1'b1; v.auth = TAG_GCM;     v.abytes = 5'd4; end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/eehc_capture.sv
// ----------------------------------------------------------------------------
// Envelope byte capture
// Counts bytes, grabs the header fields and hands a snapshot on the last byte.
// ----------------------------------------------------------------------------
`include "encrypted_envelope_header_checker_macros.svh"

module eehc_capture #(
  parameter int CNT_W    = 16,
  parameter int MAX_BYTES = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           byte_in,
  input  logic                 last_byte,
  output logic                 snap_valid,
  input  logic                 snap_ready,
  output logic [CNT_W-1:0]     snap_count,
  output eehc_pkg::snap_t      snap
);
  import eehc_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  snap_t            cur, cur_next;
  logic             in_acc;
  logic [CMP_W-1:0] pos, vpos;

  assign in_ready = !snap_valid || snap_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    pos             = CMP_W'(byte_count);
    vpos            = CMP_W'(cur.id_len) + CMP_W'(1);
    cur_next        = cur;
    byte_count_next = byte_count;
    if (byte_count < CNT_W'(MAX_BYTES)) begin
      if (pos == '0) begin
        cur_next.id_len = byte_in;
      end else if (pos == vpos) begin
        cur_next.version = byte_in;
      end else if (pos > vpos && pos <= vpos + CMP_W'(3)) begin
        cur_next.iters = {cur.iters[15:0], byte_in};
      end
      byte_count_next = byte_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      cur        <= '0;
      snap_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        if (last_byte) begin
          byte_count <= '0;
          cur        <= '0;
        end else begin
          byte_count <= byte_count_next;
          cur        <= cur_next;
        end
      end
      if (in_acc && last_byte) begin
        snap_valid <= 1'b1;
      end else if (snap_ready) begin
        snap_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && last_byte) begin
      snap_count <= byte_count_next;
      snap       <= cur_next;
    end
  end

  `EEHC_ASSERT_NEXT(a_clear_after_last, in_acc && last_byte, byte_count == '0,
    "byte count not cleared after last byte")
  `EEHC_ASSERT_NEXT(a_snap_after_last, in_acc && last_byte, snap_valid,
    "no snapshot after last byte")
  `EEHC_ASSERT_NOW(a_count_bound, 1'b1, byte_count <= CNT_W'(MAX_BYTES),
    "byte count above bound")

endmodule

FILE: hdl/eehc_decode.sv
// ----------------------------------------------------------------------------
// Envelope header decode
// Checks a snapshot, looks up the version and registers the result.
// ----------------------------------------------------------------------------
`include "encrypted_envelope_header_checker_macros.svh"

module eehc_decode #(
  parameter int CNT_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  eehc_pkg::cfg_t       cfg,
  input  logic                 snap_valid,
  output logic                 snap_ready,
  input  logic [CNT_W-1:0]     snap_count,
  input  eehc_pkg::snap_t      snap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output eehc_pkg::result_t    result
);
  import eehc_pkg::*;

  logic [CMP_W-1:0] n, header, need;
  logic [39:0]      prod;
  ver_info_t        vi;
  result_t          res_next;

  assign snap_ready = !out_valid || out_ready;

  always_comb begin
    n        = CMP_W'(snap_count);
    header   = CMP_W'(snap.id_len) + CMP_W'(HDR_FIXED);
    prod     = 40'(snap.iters) * 40'(cfg.iteration_scale);
    vi       = ver_lookup(snap.version);
    need     = header + CMP_W'(vi.iv)
             + ((vi.mode == CIPHER_ECB || vi.mode == CIPHER_CBC) ? CMP_W'(16) : CMP_W'(1))
             + ((vi.auth != TAG_HIDDEN) ? CMP_W'(vi.abytes) : '0);
    res_next = '0;
    if (n < CMP_W'(MIN_ENVELOPE)) begin
      res_next.status = ST_TINY;
    end else if (snap.id_len == '0 || snap.id_len > cfg.max_id_length) begin
      res_next.status = ST_BAD_ID_LEN;
    end else if (n < header) begin
      res_next.status = ST_SHORT_HEADER;
    end else begin
      res_next.id_length       = snap.id_len;
      res_next.version_code    = snap.version;
      res_next.iteration_count = (snap.iters <= 24'(cfg.iteration_scale))
                               ? prod[31:0] : 32'(snap.iters);
      if (!vi.hit) begin
        res_next.status = ST_UNKNOWN_VER;
      end else begin
        res_next.cipher_mode = vi.mode;
        res_next.iv_bytes    = vi.iv;
        res_next.pad_kind    = vi.pad;
        res_next.compressed  = vi.comp;
        res_next.auth_kind   = vi.auth;
        res_next.tag_bytes   = vi.abytes;
        if (n < need) begin
          res_next.status = ST_SHORT_PAYLOAD;
        end else begin
          res_next.status      = ST_OK;
          res_next.envelope_ok = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_valid && snap_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      result <= res_next;
    end
  end

  `EEHC_ASSERT_NOW(a_ok_means_ok, out_valid,
    result.envelope_ok == (result.status == ST_OK),
    "envelope_ok disagrees with status")
  `EEHC_ASSERT_NOW(a_early_fail_zero,
    out_valid && (result.status == ST_TINY || result.status == ST_BAD_ID_LEN
                  || result.status == ST_SHORT_HEADER),
    result.id_length == '0 && result.iteration_count == '0 && result.iv_bytes == '0,
    "fields not zero on early failure")
  `EEHC_ASSERT_NOW(a_fill_zero, out_valid, result.fill == '0,
    "fill bits not zero")

endmodule

FILE: hdl/encrypted_envelope_header_checker.sv
// ----------------------------------------------------------------------------
// Encrypted envelope header checker
// Streams envelope bytes in and returns one header verdict per envelope.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: one envelope byte per transaction on s_tdata[7:0], s_tlast
//    high on the final byte. A byte is taken on every cycle with s_tvalid
//    and s_tready high, so one byte per cycle is sustained unless s_tready drops.
//  - Output stream: one result transaction per envelope on m_tdata. The last
//    byte loads the snapshot register when it is accepted; the snapshot then
//    loads the result register once that register is free, and m_tvalid
//    rises with that load. Non-final bytes produce no output.
//  - Throughput: with m_tready high, up to one result per cycle. Snapshot and
//    result registers give two slots of buffering.
//  - Stall: when m_tready is low the result holds and the next verdict waits
//    in the snapshot register; once both are full s_tready drops for every
//    byte until the result is taken (m_tready reaches s_tready through logic).
//  - Reset (rst, synchronous): counters and captured fields clear, both
//    stages empty, max_id_length = 255, iteration_scale = 10000.
//  - Config over APB at 0x0 (max_id_length) and 0x4 (iteration_scale);
//    write only while idle.
// ----------------------------------------------------------------------------
module encrypted_envelope_header_checker #(
  parameter int MAX_ENVELOPE_BYTES = 65535
) (
  input  logic        clk,
  input  logic        rst,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tlast,   // last_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] envelope_ok, [3:1] status, [11:4] id_length, [19:12] version_code,
  // [51:20] iteration_count, [53:52] cipher_mode, [58:54] iv_bytes,
  // [60:59] pad_kind, [61] compressed, [63:62] auth_kind,
  // [68:64] tag_bytes, [71:69] zero
  output logic [71:0] m_tdata
);
  import eehc_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENVELOPE_BYTES + 1);

  cfg_t              cfg;
  logic              snap_valid, snap_ready;
  logic [CNT_W-1:0]  snap_count;
  snap_t             snap;
  result_t           result;
  logic              wr_en;

  // APB: zero wait states, write lands on the access phase
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_id_length   <= 8'd255;
      cfg.iteration_scale <= 16'd10000;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_MAX_ID_LEN: cfg.max_id_length   <= pwdata[7:0];
        REG_ITER_SCALE: cfg.iteration_scale <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MAX_ID_LEN: prdata = {24'd0, cfg.max_id_length};
      REG_ITER_SCALE: prdata = {16'd0, cfg.iteration_scale};
      default:        prdata = '0;
    endcase
  end

  // byte counter and header capture
  eehc_capture #(
    .CNT_W     (CNT_W),
    .MAX_BYTES (MAX_ENVELOPE_BYTES)
  ) u_capture (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .byte_in    (s_tdata),
    .last_byte  (s_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_count (snap_count),
    .snap       (snap)
  );

  // checks, version lookup, iteration decode, result register
  eehc_decode #(
    .CNT_W (CNT_W)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_count (snap_count),
    .snap       (snap),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result)
  );

  assign m_tdata = result;

endmodule

FILE: tb/encrypted_envelope_header_checker_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Envelope header checker testbench
// Streams envelopes byte by byte into the checker and scores every verdict
// against an in-bench predictor of the header rules: directed envelopes for
// each status, register sweeps with random traffic and output back-pressure.
// ----------------------------------------------------------------------------
module encrypted_envelope_header_checker_test;
  import eehc_pkg::*;

  localparam int ENVELOPE_LIMIT = 65535;    // byte count saturates here
  localparam int HOLD_CYCLES    = 400;      // long receiver hold-off
  localparam int CYCLE_LIMIT    = 1000000;  // run watchdog
  localparam int SLOT_COUNT     = 12;       // entries in the version table

  // one row of the version table
  typedef struct packed {
    logic [7:0] code;
    logic [1:0] mode;
    logic [4:0] iv;
    logic [1:0] pad;
    logic       comp;
    logic [1:0] auth;
    logic [4:0] abytes;
  } cipher_profile_t;

  typedef enum int {
    ENV_GOOD,
    ENV_SHORT_PAYLOAD,
    ENV_TRUNCATED,
    ENV_BAD_ID,
    ENV_UNKNOWN_VER,
    ENV_NOISE
  } env_kind_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] byte_in
  logic        s_tlast = 1'b0;   // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] envelope_ok, [3:1] status, [11:4] id_length, [19:12] version_code,
  // [51:20] iteration_count, [53:52] cipher_mode, [58:54] iv_bytes,
  // [60:59] pad_kind, [61] compressed, [63:62] auth_kind,
  // [68:64] tag_bytes, [71:69] zero
  logic [71:0] m_tdata;

  encrypted_envelope_header_checker #(
    .MAX_ENVELOPE_BYTES(ENVELOPE_LIMIT)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies and the envelope being assembled
  // --------------------------------------------------------------------------
  logic [7:0]  cfg_max_id = 8'd255;
  logic [15:0] cfg_scale  = 16'd10000;
  int          seen_bytes = 0;
  logic [7:0]  cap_id_len = '0;
  logic [7:0]  cap_version = '0;
  logic [23:0] cap_iters = '0;

  result_t     verdict_q[$];     // verdicts still owed by the DUT
  logic [7:0]  env_bytes[$];     // envelope under construction

  int errors = 0;
  int bytes_sent = 0;
  int envelopes_sent = 0;
  int results_checked = 0;
  int status_seen[6];
  int cycle_count = 0;

  // knobs shared by the test tasks, the byte sender and the receiver process
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic stall_token = 1'b0;
  logic stall_seen = 1'b0;
  int   stall_left = 0;

  // --------------------------------------------------------------------------
  // Version table and header rules
  // --------------------------------------------------------------------------
  function automatic cipher_profile_t profile_at(input int slot);
    cipher_profile_t p;
    p = '0;
    case (slot)
      0:  p = {8'd0,  CIPHER_ECB, 5'd0,  PADDING_NUL,   1'b0, TAG_HIDDEN,  5'd16};
      1:  p = {8'd1,  CIPHER_CBC, 5'd16, PADDING_NUL,   1'b0, TAG_HIDDEN,  5'd16};
      2:  p = {8'd5,  CIPHER_ECB, 5'd0,  PADDING_NUL,   1'b0, TAG_EXPOSED, 5'd3};
      3:  p = {8'd6,  CIPHER_ECB, 5'd0,  PADDING_PKCS7, 1'b0, TAG_HIDDEN,  5'd4};
      4:  p = {8'd7,  CIPHER_ECB, 5'd0,  PADDING_PKCS7, 1'b1, TAG_HIDDEN,  5'd4};
      5:  p = {8'd10, CIPHER_CBC, 5'd16, PADDING_NUL,   1'b0, TAG_EXPOSED, 5'd4};
      6:  p = {8'd11, CIPHER_CBC, 5'd16, PADDING_PKCS7, 1'b0, TAG_HIDDEN,  5'd4};
      7:  p = {8'd12, CIPHER_CBC, 5'd16, PADDING_PKCS7, 1'b1, TAG_HIDDEN,  5'd4};
      8:  p = {8'd15, CIPHER_CTR, 5'd12, PADDING_NONE,  1'b0, TAG_HIDDEN,  5'd4};
      9:  p = {8'd16, CIPHER_CTR, 5'd12, PADDING_NONE,  1'b1, TAG_HIDDEN,  5'd4};
      10: p = {8'd20, CIPHER_GCM, 5'd12, PADDING_NONE,  1'b0, TAG_GCM,     5'd4};
      11: p = {8'd21, CIPHER_GCM, 5'd12, PADDING_NONE,  1'b1, TAG_GCM,     5'd4};
      default: p = '0;
    endcase
    return p;
  endfunction

  // slot of a version code, -1 when the code is not in the table
  function automatic int cipher_slot(input logic [7:0] code);
    cipher_profile_t p;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      p = profile_at(i);
      if (p.code == code) return i;
    end
    return -1;
  endfunction

  // bytes needed past the header: IV, smallest ciphertext, tag if it is sent
  function automatic int payload_floor(input cipher_profile_t p);
    int min_ct;
    int tag;
    min_ct = (p.mode == CIPHER_ECB || p.mode == CIPHER_CBC) ? 16 : 1;
    tag = (p.auth != TAG_HIDDEN) ? int'(p.abytes) : 0;
    return int'(p.iv) + min_ct + tag;
  endfunction

  // verdict for the envelope held in the predictor state
  function automatic result_t header_verdict();
    result_t r;
    int n;
    int idl;
    int hdr;
    int slot;
    longint unsigned val;
    longint unsigned iters;
    cipher_profile_t p;
    r = '0;
    n = seen_bytes;
    idl = int'(cap_id_len);
    hdr = 5 + idl;
    if (n < 6) begin
      r.status = ST_TINY;
    end else if (idl == 0 || idl > int'(cfg_max_id)) begin
      r.status = ST_BAD_ID_LEN;
    end else if (n < hdr) begin
      r.status = ST_SHORT_HEADER;
    end else begin
      val = 64'(cap_iters);
      // compact counts are multiples of the scale
      iters = (val <= 64'(cfg_scale)) ? val * 64'(cfg_scale) : val;
      r.id_length = cap_id_len;
      r.version_code = cap_version;
      r.iteration_count = iters[31:0];
      slot = cipher_slot(cap_version);
      if (slot < 0) begin
        r.status = ST_UNKNOWN_VER;
      end else begin
        p = profile_at(slot);
        r.cipher_mode = p.mode;
        r.iv_bytes = p.iv;
        r.pad_kind = p.pad;
        r.compressed = p.comp;
        r.auth_kind = p.auth;
        r.tag_bytes = p.abytes;
        if (n < hdr + payload_floor(p)) begin
          r.status = ST_SHORT_PAYLOAD;
        end else begin
          r.status = ST_OK;
          r.envelope_ok = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // fold one accepted byte into the predictor
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int vpos;
    if (seen_bytes < ENVELOPE_LIMIT) begin
      vpos = 1 + int'(cap_id_len);
      if (seen_bytes == 0) begin
        cap_id_len = b;
      end else if (seen_bytes == vpos) begin
        cap_version = b;
      end else if (seen_bytes > vpos && seen_bytes <= vpos + 3) begin
        cap_iters = {cap_iters[15:0], b};
      end
      seen_bytes++;
    end
    if (last) begin
      verdict_q.push_back(header_verdict());
      seen_bytes = 0;
      cap_id_len = '0;
      cap_version = '0;
      cap_iters = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Input stream: one transaction per byte
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (tx_idle_on && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    absorb_byte(b, last);
  endtask

  task automatic send_envelope();
    for (int i = 0; i < env_bytes.size(); i++)
      send_byte(env_bytes[i], i == env_bytes.size() - 1);
    envelopes_sent++;
  endtask

  // stop offering bytes and wait for every owed verdict
  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB port
  // --------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_readback(input logic [2:0] addr, input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, addr, 32'd0, rd);
    if (rd !== want) begin
      $display("%0t register 0x%0h readback: expected %0d, actual %0d",
               $time, addr, want, rd);
      errors++;
    end
  endtask

  // registers change only with the block idle
  task automatic program_registers(input logic [7:0] max_id, input logic [15:0] scale);
    logic [31:0] unused;
    wait_results_drained();
    repeat (4) @(posedge clk);
    apb_access(1'b1, {REG_MAX_ID_LEN, 2'b00}, {24'd0, max_id}, unused);
    apb_access(1'b1, {REG_ITER_SCALE, 2'b00}, {16'd0, scale}, unused);
    cfg_max_id = max_id;
    cfg_scale = scale;
    check_readback({REG_MAX_ID_LEN, 2'b00}, {24'd0, max_id});
    check_readback({REG_ITER_SCALE, 2'b00}, {16'd0, scale});
  endtask

  // --------------------------------------------------------------------------
  // Envelope builders
  // --------------------------------------------------------------------------
  // length byte, id bytes, version, big-endian iteration bytes
  task automatic form_header(input int idl, input logic [7:0] ver,
                             input logic [23:0] iters);
    env_bytes.delete();
    env_bytes.push_back(idl[7:0]);
    for (int i = 0; i < idl; i++) env_bytes.push_back(8'($urandom_range(255)));
    env_bytes.push_back(ver);
    env_bytes.push_back(iters[23:16]);
    env_bytes.push_back(iters[15:8]);
    env_bytes.push_back(iters[7:0]);
  endtask

  // cut the envelope back, or fill it out with random payload
  task automatic pad_to(input int len);
    while (env_bytes.size() > len) env_bytes.delete(env_bytes.size() - 1);
    while (env_bytes.size() < len) env_bytes.push_back(8'($urandom_range(255)));
  endtask

  // mostly short ids, now and then anything up to the limit
  function automatic int pick_id_len();
    int cap;
    cap = (cfg_max_id < 6) ? int'(cfg_max_id) : 6;
    case ($urandom_range(9))
      0: return int'(cfg_max_id);
      1: return int'($urandom_range(1, cfg_max_id));
      default: return int'($urandom_range(1, cap));
    endcase
  endfunction

  // stored values around the scale threshold, or anywhere in the 24-bit range
  function automatic logic [23:0] pick_iterations();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return {8'd0, cfg_scale};
      2: return {8'd0, cfg_scale} + 24'd1;
      3: return 24'($urandom_range(cfg_scale));
      default: return 24'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  task automatic make_random_envelope();
    int r;
    int idl;
    int hdr;
    int need;
    logic [7:0] ver;
    cipher_profile_t p;
    env_kind_t kind;
    r = $urandom_range(99);
    if (r < 45) kind = ENV_GOOD;
    else if (r < 60) kind = ENV_SHORT_PAYLOAD;
    else if (r < 70) kind = ENV_TRUNCATED;
    else if (r < 80) kind = ENV_BAD_ID;
    else if (r < 90) kind = ENV_UNKNOWN_VER;
    else kind = ENV_NOISE;
    case (kind)
      ENV_GOOD, ENV_SHORT_PAYLOAD: begin
        idl = pick_id_len();
        p = profile_at($urandom_range(SLOT_COUNT - 1));
        form_header(idl, p.code, pick_iterations());
        hdr = 5 + idl;
        need = hdr + payload_floor(p);
        if (kind == ENV_GOOD) pad_to(need + $urandom_range(0, 6));
        else pad_to($urandom_range(hdr, need - 1));
      end
      ENV_TRUNCATED: begin
        idl = pick_id_len();
        p = profile_at($urandom_range(SLOT_COUNT - 1));
        form_header(idl, p.code, pick_iterations());
        pad_to($urandom_range(1, 4 + idl));
      end
      ENV_BAD_ID: begin
        if (cfg_max_id != 8'd255 && $urandom_range(1) == 1)
          idl = $urandom_range(int'(cfg_max_id) + 1, 255);
        else
          idl = 0;
        form_header(idl, 8'($urandom_range(255)), 24'($urandom_range(24'hFFFFFF)));
        pad_to($urandom_range(6, 30));
      end
      ENV_UNKNOWN_VER: begin
        idl = pick_id_len();
        ver = 8'($urandom_range(255));
        while (cipher_slot(ver) >= 0) ver = 8'($urandom_range(255));
        form_header(idl, ver, pick_iterations());
        pad_to($urandom_range(5 + idl, 45 + idl));
      end
      default: begin
        env_bytes.delete();
        pad_to($urandom_range(1, 24));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Output stream: receiver ready with random idling and a counted hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_token != stall_seen) begin
      stall_seen <= stall_token;
      stall_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(99) < 14) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // every result transaction is scored against the oldest owed verdict
  always @(posedge clk) begin : score_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (verdict_q.size() == 0) begin
        $display("%0t unexpected result transaction %h", $time, m_tdata);
        errors++;
      end else begin
        want = verdict_q.pop_front();
        check_field("envelope_ok", 32'(want.envelope_ok), 32'(got.envelope_ok));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("id_length", 32'(want.id_length), 32'(got.id_length));
        check_field("version_code", 32'(want.version_code), 32'(got.version_code));
        check_field("iteration_count", want.iteration_count, got.iteration_count);
        check_field("cipher_mode", 32'(want.cipher_mode), 32'(got.cipher_mode));
        check_field("iv_bytes", 32'(want.iv_bytes), 32'(got.iv_bytes));
        check_field("pad_kind", 32'(want.pad_kind), 32'(got.pad_kind));
        check_field("compressed", 32'(want.compressed), 32'(got.compressed));
        check_field("auth_kind", 32'(want.auth_kind), 32'(got.auth_kind));
        check_field("tag_bytes", 32'(want.tag_bytes), 32'(got.tag_bytes));
        check_field("fill", 32'(want.fill), 32'(got.fill));
        status_seen[int'(want.status)]++;
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t watchdog expired, %0d verdicts outstanding", $time, verdict_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_register_defaults();
    check_readback({REG_MAX_ID_LEN, 2'b00}, 32'd255);
    check_readback({REG_ITER_SCALE, 2'b00}, 32'd10000);
  endtask

  // at least one envelope per status, with the field extremes
  task automatic test_directed_verdicts();
    form_header(255, 8'hFF, 24'hFFFFFF);   // a lone byte
    pad_to(1);
    send_envelope();
    form_header(1, 8'd0, 24'd0);           // one byte short of the minimum
    pad_to(5);
    send_envelope();
    form_header(0, 8'hFF, 24'hFFFFFF);     // zero id length
    pad_to(6);
    send_envelope();
    form_header(3, 8'd0, 24'd0);           // ends inside the header
    pad_to(6);
    send_envelope();
    form_header(1, 8'hFF, 24'hFFFFFF);     // unknown version, raw count
    pad_to(6);
    send_envelope();
    form_header(1, 8'd5, 24'd1);           // no ciphertext, exposed tag missing
    pad_to(6);
    send_envelope();
    form_header(1, 8'd20, 24'd10000);      // exact fit, count at the scale
    pad_to(23);
    send_envelope();
  endtask

  task automatic test_random_traffic(input logic [7:0] max_id, input logic [15:0] scale,
                                     input int items, input logic idle);
    int start;
    program_registers(max_id, scale);
    tx_idle_on = idle;
    rx_idle_on = idle;
    start = bytes_sent;
    while (bytes_sent - start < items) begin
      make_random_envelope();
      send_envelope();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off while short envelopes keep coming, so the result
  // pipe fills and the input stalls; then the sender waits for all results
  task automatic test_output_backpressure();
    cipher_profile_t p;
    stall_token <= ~stall_token;
    for (int k = 0; k < 12; k++) begin
      p = profile_at(k);
      form_header(1, p.code, pick_iterations());
      pad_to($urandom_range(6, 10));
      send_envelope();
    end
    wait_results_drained();
    for (int k = 0; k < 4; k++) begin
      make_random_envelope();
      send_envelope();
    end
  endtask

  initial begin
    for (int i = 0; i < 6; i++) status_seen[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_directed_verdicts();
    test_random_traffic(8'd255, 16'd10000, 350, 1'b1);
    test_random_traffic(8'd1, 16'd1, 300, 1'b1);
    test_random_traffic(8'd255, 16'd65535, 350, 1'b0);   // no idling at all
    test_random_traffic(8'($urandom_range(1, 255)), 16'($urandom_range(1, 65535)),
                        450, 1'b1);
    test_output_backpressure();

    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d envelopes (%0d bytes), %0d verdicts checked, with a long stall",
             envelopes_sent, bytes_sent, results_checked);
    $display("statuses: ok %0d, tiny %0d, bad id %0d, short header %0d, unknown %0d, short %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/eehc_pkg.sv
hdl/eehc_capture.sv
hdl/eehc_decode.sv
hdl/encrypted_envelope_header_checker.sv
tb/encrypted_envelope_header_checker_test.sv
